### rtl/three_wire_rtc_serial_master_core_macros.svh
// assertion helpers shared by the core modules
// both expect signals named clock and reset in the module that uses them
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_CORE_MACROS_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TWRSM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TWRSM_ASSERT_NEVER(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(prop)) else $error(msg);
`else
`define TWRSM_ASSERT(label, prop, msg)
`define TWRSM_ASSERT_NEVER(label, prop, msg)
`endif

`endif

### rtl/twrsm_pkg.sv
package twrsm_pkg;

   localparam int BYTE_BITS       = 8;
   localparam int BIT_INDEX_WIDTH = 3;
   localparam logic [BIT_INDEX_WIDTH-1:0] LAST_BIT = BIT_INDEX_WIDTH'(BYTE_BITS - 1);

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INACTIVE_DELAY     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENABLE_SETUP_DELAY = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DATA_SETUP_DELAY   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLOCK_HIGH_DELAY   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTE_GAP_DELAY     = 3'd4;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef struct packed {
      logic                 start_req;
      logic                 op;
      logic [BYTE_BITS-1:0] address;
      logic [BYTE_BITS-1:0] write_data;
      logic                 io_in;
   } req_payload_type;

   typedef struct packed {
      logic                 chip_enable;
      logic                 serial_clock;
      logic                 io_out;
      logic                 io_drive;
      logic                 busy_res;
      logic                 done_res;
      logic [BYTE_BITS-1:0] read_data;
   } rsp_payload_type;

endpackage

### rtl/twrsm_engine.sv
`include "three_wire_rtc_serial_master_core_macros.svh"

module twrsm_engine #(
   parameter int DELAY_WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     step,
   input  twrsm_pkg::req_payload_type               item,
   input  logic                                     csr_write,
   input  logic [twrsm_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [twrsm_pkg::CSR_DATA_WIDTH-1:0]     csr_data,
   output twrsm_pkg::rsp_payload_type               result
);

   typedef enum logic [11:0] {
      PH_IDLE      = 12'b0000_0000_0001,
      PH_INACT     = 12'b0000_0000_0010,
      PH_ENABLE    = 12'b0000_0000_0100,
      PH_ESETUP    = 12'b0000_0000_1000,
      PH_ADDR_LOW  = 12'b0000_0001_0000,
      PH_ADDR_HIGH = 12'b0000_0010_0000,
      PH_GAP       = 12'b0000_0100_0000,
      PH_DATA_LOW  = 12'b0000_1000_0000,
      PH_DATA_HIGH = 12'b0001_0000_0000,
      PH_RD_LOW    = 12'b0010_0000_0000,
      PH_RD_HIGH   = 12'b0100_0000_0000,
      PH_DONE      = 12'b1000_0000_0000
   } phase_type;

   localparam int BW = twrsm_pkg::BYTE_BITS;
   localparam int IW = twrsm_pkg::BIT_INDEX_WIDTH;

   logic [DELAY_WIDTH-1:0] inactive_delay_ff, enable_setup_delay_ff, data_setup_delay_ff;
   logic [DELAY_WIDTH-1:0] clock_high_delay_ff, byte_gap_delay_ff;
   logic [DELAY_WIDTH-1:0] csr_value;

   phase_type              phase_ff, phase_in;
   logic [IW-1:0]          bit_index_ff, bit_index_in;
   logic [DELAY_WIDTH-1:0] wait_count_ff, wait_count_in;
   logic [BW-1:0]          send_shift_ff, send_shift_in;
   logic [BW-1:0]          receive_shift_ff, receive_shift_in;
   logic                   latched_kind_ff, latched_kind_in;
   logic [BW-1:0]          latched_data_ff, latched_data_in;

   logic [DELAY_WIDTH-1:0] wait_dec;
   logic [DELAY_WIDTH-1:0] setup_wait;

   assign csr_value = DELAY_WIDTH'(csr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         inactive_delay_ff     <= '0;
         enable_setup_delay_ff <= '0;
         data_setup_delay_ff   <= '0;
         clock_high_delay_ff   <= '0;
         byte_gap_delay_ff     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            twrsm_pkg::CSR_INACTIVE_DELAY:     inactive_delay_ff     <= csr_value;
            twrsm_pkg::CSR_ENABLE_SETUP_DELAY: enable_setup_delay_ff <= csr_value;
            twrsm_pkg::CSR_DATA_SETUP_DELAY:   data_setup_delay_ff   <= csr_value;
            twrsm_pkg::CSR_CLOCK_HIGH_DELAY:   clock_high_delay_ff   <= csr_value;
            twrsm_pkg::CSR_BYTE_GAP_DELAY:     byte_gap_delay_ff     <= csr_value;
            default: begin
            end
         endcase
      end
   end

   // saturating countdown shared by the wait phases
   assign wait_dec = (wait_count_ff != '0) ? wait_count_ff - DELAY_WIDTH'(1) : '0;

   // enable setup less data setup, clamped at zero, writes only
   assign setup_wait = (latched_kind_ff == twrsm_pkg::OP_WRITE &&
                        enable_setup_delay_ff > data_setup_delay_ff) ?
                       enable_setup_delay_ff - data_setup_delay_ff : '0;

   always_comb begin
      phase_in         = phase_ff;
      bit_index_in     = bit_index_ff;
      wait_count_in    = wait_count_ff;
      send_shift_in    = send_shift_ff;
      receive_shift_in = receive_shift_ff;
      latched_kind_in  = latched_kind_ff;
      latched_data_in  = latched_data_ff;

      result              = '0;
      result.io_drive     = 1'b1;
      result.busy_res     = 1'b1;

      case (phase_ff)
         PH_INACT: begin
            wait_count_in = wait_dec;
            if (wait_dec == '0) begin
               phase_in = PH_ENABLE;
            end
         end
         PH_ENABLE: begin
            result.chip_enable = 1'b1;
            if (setup_wait != '0) begin
               phase_in      = PH_ESETUP;
               wait_count_in = setup_wait;
            end else begin
               phase_in      = PH_ADDR_LOW;
               bit_index_in  = '0;
               wait_count_in = data_setup_delay_ff;
            end
         end
         PH_ESETUP: begin
            result.chip_enable = 1'b1;
            wait_count_in      = wait_dec;
            if (wait_dec == '0) begin
               phase_in      = PH_ADDR_LOW;
               bit_index_in  = '0;
               wait_count_in = data_setup_delay_ff;
            end
         end
         PH_ADDR_LOW, PH_DATA_LOW: begin
            result.chip_enable = 1'b1;
            result.io_out      = send_shift_ff[0];
            if (wait_count_ff == '0) begin
               phase_in      = (phase_ff == PH_ADDR_LOW) ? PH_ADDR_HIGH : PH_DATA_HIGH;
               wait_count_in = clock_high_delay_ff;
            end else begin
               wait_count_in = wait_dec;
            end
         end
         PH_ADDR_HIGH, PH_DATA_HIGH: begin
            result.chip_enable  = 1'b1;
            result.serial_clock = 1'b1;
            result.io_out       = send_shift_ff[0];
            if (wait_count_ff != '0) begin
               wait_count_in = wait_dec;
            end else begin
               send_shift_in = {1'b0, send_shift_ff[BW-1:1]};
               if (bit_index_ff != twrsm_pkg::LAST_BIT) begin
                  bit_index_in  = bit_index_ff + IW'(1);
                  phase_in      = (phase_ff == PH_ADDR_HIGH) ? PH_ADDR_LOW : PH_DATA_LOW;
                  wait_count_in = data_setup_delay_ff;
               end else if (phase_ff == PH_DATA_HIGH) begin
                  phase_in = PH_DONE;
               end else if (latched_kind_ff == twrsm_pkg::OP_WRITE) begin
                  if (byte_gap_delay_ff != '0) begin
                     phase_in      = PH_GAP;
                     wait_count_in = byte_gap_delay_ff;
                  end else begin
                     phase_in      = PH_DATA_LOW;
                     send_shift_in = latched_data_ff;
                     bit_index_in  = '0;
                     wait_count_in = data_setup_delay_ff;
                  end
               end else begin
                  phase_in         = PH_RD_LOW;
                  bit_index_in     = '0;
                  receive_shift_in = '0;
               end
            end
         end
         PH_GAP: begin
            result.chip_enable = 1'b1;
            wait_count_in      = wait_dec;
            if (wait_dec == '0) begin
               phase_in      = PH_DATA_LOW;
               send_shift_in = latched_data_ff;
               bit_index_in  = '0;
               wait_count_in = data_setup_delay_ff;
            end
         end
         PH_RD_LOW: begin
            result.chip_enable = 1'b1;
            result.io_drive    = 1'b0;
            receive_shift_in   = {item.io_in, receive_shift_ff[BW-1:1]};
            phase_in           = PH_RD_HIGH;
         end
         PH_RD_HIGH: begin
            result.chip_enable  = 1'b1;
            result.serial_clock = 1'b1;
            result.io_drive     = 1'b0;
            if (bit_index_ff != twrsm_pkg::LAST_BIT) begin
               bit_index_in = bit_index_ff + IW'(1);
               phase_in     = PH_RD_LOW;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            result.busy_res  = 1'b0;
            result.done_res  = 1'b1;
            result.read_data = (latched_kind_ff == twrsm_pkg::OP_READ) ? receive_shift_ff : '0;
            phase_in         = PH_IDLE;
         end
         default: begin
            // idle, and any code that means nothing
            result.busy_res = 1'b0;
            phase_in        = PH_IDLE;
            if (item.start_req) begin
               result.busy_res  = 1'b1;
               latched_kind_in  = item.op;
               latched_data_in  = item.write_data;
               send_shift_in    = item.address;
               receive_shift_in = '0;
               bit_index_in     = '0;
               if (item.op == twrsm_pkg::OP_WRITE && inactive_delay_ff != '0) begin
                  phase_in      = PH_INACT;
                  wait_count_in = inactive_delay_ff;
               end else begin
                  phase_in = PH_ENABLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         bit_index_ff     <= '0;
         wait_count_ff    <= '0;
         send_shift_ff    <= '0;
         receive_shift_ff <= '0;
         latched_kind_ff  <= 1'b0;
         latched_data_ff  <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         bit_index_ff     <= bit_index_in;
         wait_count_ff    <= wait_count_in;
         send_shift_ff    <= send_shift_in;
         receive_shift_ff <= receive_shift_in;
         latched_kind_ff  <= latched_kind_in;
         latched_data_ff  <= latched_data_in;
      end
   end

   `TWRSM_ASSERT(a_done_to_idle,
      (step && phase_ff == PH_DONE) |=> (phase_ff == PH_IDLE),
      "done did not return to idle")
   `TWRSM_ASSERT(a_read_start,
      (step && phase_ff == PH_IDLE && item.start_req && item.op == twrsm_pkg::OP_READ)
         |=> (phase_ff == PH_ENABLE),
      "read start did not raise enable")
   `TWRSM_ASSERT(a_rx_only_reads,
      (phase_ff == PH_RD_LOW || phase_ff == PH_RD_HIGH) |-> (latched_kind_ff == twrsm_pkg::OP_READ),
      "receive phase during a write")

endmodule

### rtl/twrsm_skid.sv
`include "three_wire_rtc_serial_master_core_macros.svh"

module twrsm_skid (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  twrsm_pkg::rsp_payload_type  in_data,
   output logic                        in_stall,
   output logic                        out_valid,
   output twrsm_pkg::rsp_payload_type  out_data,
   input  logic                        out_stall
);

   logic                        out_valid_ff, out_valid_in;
   twrsm_pkg::rsp_payload_type  out_data_ff, out_data_in;
   logic                        skid_valid_ff, skid_valid_in;
   twrsm_pkg::rsp_payload_type  skid_data_ff, skid_data_in;
   logic                        out_free;

   assign out_free = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            if (in_valid) begin
               out_data_in = in_data;
            end
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   `TWRSM_ASSERT_NEVER(a_skid_without_out, (skid_valid_ff && !out_valid_ff), "skid holds an item ahead of an empty output")
   `TWRSM_ASSERT(a_skid_fill, $rose(skid_valid_ff) |-> $past(out_valid_ff && out_stall), "skid filled while output was free")
   `TWRSM_ASSERT(a_skid_drain, $fell(skid_valid_ff) |-> out_valid_ff, "skid drained without refilling the output")

endmodule

### rtl/three_wire_rtc_serial_master_core.sv
// three-wire serial master: chip enable, serial clock and a shared data line
//
// req channel: one item per tick of the pin waveform; each item carries the
//   start request, transfer kind, address and write bytes and the sampled
//   level of the data line. a start is honored only while idle
// rsp channel: exactly one item per accepted req item, in order, giving the
//   pin levels for that tick, busy, done and the byte of a finished read
// csr channel: delay registers, which the user must write only while no transfer
//   is running, the block does not enforce it; csr_ready is always high
// rsp timing: each result item is held in a register before it appears on rsp
// throughput: one item per cycle while req_stall is low; the whole tick
//   is worked out by the phase sequencer between the item and the result
//   register, and a wait counter stands in for every delay, not a stall
// rsp stall: a result that arrives while the output is stalled parks in a
//   one-deep skid stage; req_stall rises only once that skid is full and
//   drops as soon as the output is taken
// reset: synchronous, clears the sequencer to idle, all delays to zero and
//   both result slots to empty; no clearing pass, the block is usable at
//   the first cycle after reset
module three_wire_rtc_serial_master_core #(
   parameter int DELAY_WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,

   // tick items in
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  twrsm_pkg::req_payload_type               req_payload,

   // pin and status items out
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output twrsm_pkg::rsp_payload_type               rsp_payload,

   // delay register writes
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [twrsm_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [twrsm_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   logic                        req_accept;
   logic                        csr_write;
   twrsm_pkg::rsp_payload_type  step_result;

   // register writes never wait
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   // an item advances the sequencer only when taken
   assign req_accept = req_valid && !req_stall;

   // one tick of the pin sequencer per accepted item
   twrsm_engine #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (req_accept),
      .item      (req_payload),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .result    (step_result)
   );

   // result register plus skid so the req side keeps flowing under a stall
   twrsm_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (step_result),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload),
      .out_stall (rsp_stall)
   );

endmodule

### tb/sv/pin_tick_monitor.sv
`timescale 1ns / 1ps

module pin_tick_monitor #(
   parameter int DELAY_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  twrsm_pkg::req_payload_type            req_payload,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  twrsm_pkg::rsp_payload_type            rsp_payload,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [twrsm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [twrsm_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                    failures
);

   typedef enum logic [3:0] {
      SEQ_IDLE      = 4'd0,
      SEQ_INACTIVE  = 4'd2,
      SEQ_ENABLE    = 4'd3,
      SEQ_SETUP     = 4'd4,
      SEQ_ADDR_LOW  = 4'd5,
      SEQ_ADDR_HIGH = 4'd6,
      SEQ_GAP       = 4'd7,
      SEQ_DATA_LOW  = 4'd8,
      SEQ_DATA_HIGH = 4'd9,
      SEQ_RD_LOW    = 4'd10,
      SEQ_RD_HIGH   = 4'd11,
      SEQ_DONE      = 4'd12
   } seq_phase_type;

   localparam int PRINT_LIMIT = 30;

   seq_phase_type                         seq;
   logic [twrsm_pkg::BIT_INDEX_WIDTH-1:0] bit_idx;
   logic [DELAY_WIDTH-1:0]                ticks_left;
   logic [twrsm_pkg::BYTE_BITS-1:0]       out_shift;
   logic [twrsm_pkg::BYTE_BITS-1:0]       in_shift;
   logic [twrsm_pkg::BYTE_BITS-1:0]       held_data;
   logic                                  held_op;

   logic [DELAY_WIDTH-1:0]     inactive_dly;
   logic [DELAY_WIDTH-1:0]     enable_setup_dly;
   logic [DELAY_WIDTH-1:0]     data_setup_dly;
   logic [DELAY_WIDTH-1:0]     clock_high_dly;
   logic [DELAY_WIDTH-1:0]     byte_gap_dly;

   twrsm_pkg::rsp_payload_type pending_pins[$];
   int                         pending_count;
   int                         error_count;
   int                         rsp_count;

   assign failures = error_count + pending_count;

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("%0t ns: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("result item %0d: %s is %0h, expected %0h",
                                   rsp_count, name, got, want));
   endtask

   function automatic void load_byte(input seq_phase_type low_phase,
                                     input logic [twrsm_pkg::BYTE_BITS-1:0] value);
      seq        = low_phase;
      out_shift  = value;
      bit_idx    = '0;
      ticks_left = data_setup_dly;
   endfunction

   // pin levels for one tick, advancing the sequencer copy
   function automatic twrsm_pkg::rsp_payload_type next_pin_levels(
         input twrsm_pkg::req_payload_type tick);
      twrsm_pkg::rsp_payload_type pins;
      pins          = '0;
      pins.io_drive = 1'b1;
      pins.busy_res = 1'b1;
      case (seq)
         SEQ_INACTIVE: begin
            if (ticks_left != 0) ticks_left--;
            if (ticks_left == 0) seq = SEQ_ENABLE;
         end
         SEQ_ENABLE: begin
            pins.chip_enable = 1'b1;
            ticks_left = (held_op == twrsm_pkg::OP_WRITE && enable_setup_dly > data_setup_dly) ?
                         enable_setup_dly - data_setup_dly : '0;
            if (ticks_left != 0) seq = SEQ_SETUP;
            else load_byte(SEQ_ADDR_LOW, out_shift);
         end
         SEQ_SETUP: begin
            pins.chip_enable = 1'b1;
            if (ticks_left != 0) ticks_left--;
            if (ticks_left == 0) load_byte(SEQ_ADDR_LOW, out_shift);
         end
         SEQ_ADDR_LOW, SEQ_DATA_LOW: begin
            pins.chip_enable = 1'b1;
            pins.io_out      = out_shift[0];
            if (ticks_left == 0) begin
               seq        = (seq == SEQ_ADDR_LOW) ? SEQ_ADDR_HIGH : SEQ_DATA_HIGH;
               ticks_left = clock_high_dly;
            end else begin
               ticks_left--;
            end
         end
         SEQ_ADDR_HIGH, SEQ_DATA_HIGH: begin
            pins.chip_enable  = 1'b1;
            pins.serial_clock = 1'b1;
            pins.io_out       = out_shift[0];
            if (ticks_left != 0) begin
               ticks_left--;
            end else begin
               out_shift = out_shift >> 1;
               if (bit_idx != twrsm_pkg::LAST_BIT) begin
                  bit_idx++;
                  seq        = (seq == SEQ_ADDR_HIGH) ? SEQ_ADDR_LOW : SEQ_DATA_LOW;
                  ticks_left = data_setup_dly;
               end else if (seq == SEQ_DATA_HIGH) begin
                  seq = SEQ_DONE;
               end else if (held_op == twrsm_pkg::OP_WRITE) begin
                  if (byte_gap_dly != 0) begin
                     seq        = SEQ_GAP;
                     ticks_left = byte_gap_dly;
                  end else begin
                     load_byte(SEQ_DATA_LOW, held_data);
                  end
               end else begin
                  seq      = SEQ_RD_LOW;
                  bit_idx  = '0;
                  in_shift = '0;
               end
            end
         end
         SEQ_GAP: begin
            pins.chip_enable = 1'b1;
            if (ticks_left != 0) ticks_left--;
            if (ticks_left == 0) load_byte(SEQ_DATA_LOW, held_data);
         end
         SEQ_RD_LOW: begin
            pins.chip_enable = 1'b1;
            pins.io_drive    = 1'b0;
            in_shift         = {tick.io_in, in_shift[twrsm_pkg::BYTE_BITS-1:1]};
            seq              = SEQ_RD_HIGH;
         end
         SEQ_RD_HIGH: begin
            pins.chip_enable  = 1'b1;
            pins.serial_clock = 1'b1;
            pins.io_drive     = 1'b0;
            if (bit_idx != twrsm_pkg::LAST_BIT) begin
               bit_idx++;
               seq = SEQ_RD_LOW;
            end else begin
               seq = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            pins.busy_res  = 1'b0;
            pins.done_res  = 1'b1;
            pins.read_data = (held_op == twrsm_pkg::OP_READ) ? in_shift : '0;
            seq            = SEQ_IDLE;
         end
         default: begin
            pins.busy_res = tick.start_req;
            if (tick.start_req) begin
               held_op   = tick.op;
               held_data = tick.write_data;
               out_shift = tick.address;
               in_shift  = '0;
               bit_idx   = '0;
               if (held_op == twrsm_pkg::OP_WRITE && inactive_dly != 0) begin
                  seq        = SEQ_INACTIVE;
                  ticks_left = inactive_dly;
               end else begin
                  seq = SEQ_ENABLE;
               end
            end else begin
               seq = SEQ_IDLE;
            end
         end
      endcase
      return pins;
   endfunction

   always @(posedge clock) begin : track_block
      twrsm_pkg::rsp_payload_type want;
      if (reset) begin
         seq              = SEQ_IDLE;
         bit_idx          = '0;
         ticks_left       = '0;
         out_shift        = '0;
         in_shift         = '0;
         held_op          = twrsm_pkg::OP_WRITE;
         held_data        = '0;
         inactive_dly     = '0;
         enable_setup_dly = '0;
         data_setup_dly   = '0;
         clock_high_dly   = '0;
         byte_gap_dly     = '0;
         pending_pins.delete();
         pending_count    = 0;
         error_count      = 0;
         rsp_count        = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pins.size() == 0) begin
               report_mismatch($sformatf("result item %0d arrived with nothing expected",
                                         rsp_count));
            end else begin
               want = pending_pins.pop_front();
               check_field("chip_enable", 32'(rsp_payload.chip_enable),
                           32'(want.chip_enable));
               check_field("serial_clock", 32'(rsp_payload.serial_clock),
                           32'(want.serial_clock));
               check_field("io_out", 32'(rsp_payload.io_out), 32'(want.io_out));
               check_field("io_drive", 32'(rsp_payload.io_drive), 32'(want.io_drive));
               check_field("busy_res", 32'(rsp_payload.busy_res), 32'(want.busy_res));
               check_field("done_res", 32'(rsp_payload.done_res), 32'(want.done_res));
               check_field("read_data", 32'(rsp_payload.read_data), 32'(want.read_data));
            end
            rsp_count++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               twrsm_pkg::CSR_INACTIVE_DELAY:     inactive_dly     = DELAY_WIDTH'(csr_data);
               twrsm_pkg::CSR_ENABLE_SETUP_DELAY: enable_setup_dly = DELAY_WIDTH'(csr_data);
               twrsm_pkg::CSR_DATA_SETUP_DELAY:   data_setup_dly   = DELAY_WIDTH'(csr_data);
               twrsm_pkg::CSR_CLOCK_HIGH_DELAY:   clock_high_dly   = DELAY_WIDTH'(csr_data);
               twrsm_pkg::CSR_BYTE_GAP_DELAY:     byte_gap_dly     = DELAY_WIDTH'(csr_data);
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            pending_pins.push_back(next_pin_levels(req_payload));
         pending_count = pending_pins.size();
      end
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int DELAY_WIDTH     = 16;
   localparam int CYCLE_LIMIT     = 250_000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_CYCLES    = 10;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_TICKS     = 70;

   typedef enum {IO_LOW, IO_HIGH, IO_RANDOM} io_mode_type;
   typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   twrsm_pkg::req_payload_type            req_payload;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   twrsm_pkg::rsp_payload_type            rsp_payload;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [twrsm_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [twrsm_pkg::CSR_DATA_WIDTH-1:0]  csr_data;

   int failures;
   int cycle_count = 0;
   int sent_count;
   int got_count = 0;
   int done_count = 0;
   logic last_busy = 1'b0;
   int burst_left;

   // quiet: no gaps on the sender and no stalls on the receiver
   bit quiet;
   bit hold_off_req;
   bit hold_off_served;

   three_wire_rtc_serial_master_core #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   pin_tick_monitor #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) pin_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures)
   );

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("three_wire_rtc_serial_master_core test failed");
         $finish;
      end
   end

   // result side bookkeeping for the stimulus; nonblocking so the sender
   // sees the values from before the edge when it looks at a rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_count <= got_count + 1;
         last_busy <= rsp_payload.busy_res;
         if (rsp_payload.done_res) done_count <= done_count + 1;
      end
   end

   // receiver: randomly chosen stall modes, plus one long hold-off on request
   // so the skid fills and req_stall rises
   initial begin : rsp_stall_pattern
      stall_mode_type mode;
      int             mode_left;
      mode            = STALL_NONE;
      mode_left       = 0;
      rsp_stall       = 1'b0;
      hold_off_served = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_off_served) begin
            hold_off_served = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(8, 60);
         end
         mode_left--;
         if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            case (mode)
               STALL_HALF:   rsp_stall <= 1'($urandom_range(0, 1));
               STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
               STALL_TOGGLE: rsp_stall <= mode_left[0];
               default:      rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   function automatic logic io_level(input io_mode_type io_mode);
      case (io_mode)
         IO_LOW:  return 1'b0;
         IO_HIGH: return 1'b1;
         default: return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // zero half the time, else a short wait
   function automatic logic [twrsm_pkg::CSR_DATA_WIDTH-1:0] short_delay();
      return $urandom_range(0, 1) ? '0 : 16'($urandom_range(1, 3));
   endfunction

   // one tick item; the sender runs in bursts with random idle gaps, possibly none, between them
   task automatic send_tick(input twrsm_pkg::req_payload_type item);
      int gap;
      if (burst_left == 0) begin
         gap        = quiet ? 0 : $urandom_range(0, 6);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      sent_count++;
   endtask

   // pause the sender until every result is back and the sequencer is
   // idle; a transfer still running gets idle ticks until it finishes
   task automatic settle();
      twrsm_pkg::req_payload_type item;
      item = '0;
      forever begin
         @(negedge clock);
         req_valid <= 1'b0;
         if (got_count == sent_count && !last_busy) break;
         if (got_count == sent_count) begin
            item.io_in = 1'($urandom_range(0, 1));
            send_tick(item);
         end
      end
   endtask

   task automatic write_csr(input logic [twrsm_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [twrsm_pkg::CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // only called with the block idle and nothing outstanding
   task automatic write_delays(input logic [twrsm_pkg::CSR_DATA_WIDTH-1:0] inactive,
                               input logic [twrsm_pkg::CSR_DATA_WIDTH-1:0] enable_setup,
                               input logic [twrsm_pkg::CSR_DATA_WIDTH-1:0] data_setup,
                               input logic [twrsm_pkg::CSR_DATA_WIDTH-1:0] clock_high,
                               input logic [twrsm_pkg::CSR_DATA_WIDTH-1:0] byte_gap);
      write_csr(twrsm_pkg::CSR_INACTIVE_DELAY, inactive);
      write_csr(twrsm_pkg::CSR_ENABLE_SETUP_DELAY, enable_setup);
      write_csr(twrsm_pkg::CSR_DATA_SETUP_DELAY, data_setup);
      write_csr(twrsm_pkg::CSR_CLOCK_HIGH_DELAY, clock_high);
      write_csr(twrsm_pkg::CSR_BYTE_GAP_DELAY, byte_gap);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one start tick, then ticks until the done item comes back; with
   // keep_start the start request stays high through the whole transfer
   task automatic do_transfer(input logic kind,
                              input logic [twrsm_pkg::BYTE_BITS-1:0] addr,
                              input logic [twrsm_pkg::BYTE_BITS-1:0] data,
                              input bit keep_start, input io_mode_type io_mode);
      twrsm_pkg::req_payload_type item;
      int                         dones_before;
      dones_before     = done_count;
      item.start_req   = 1'b1;
      item.op          = kind;
      item.address     = addr;
      item.write_data  = data;
      item.io_in       = io_level(io_mode);
      send_tick(item);
      item.start_req = keep_start;
      while (done_count == dones_before) begin
         item.io_in = io_level(io_mode);
         send_tick(item);
      end
      settle();
   endtask

   // free-running ticks: random starts land both while idle and as noise
   // during a transfer, data line level random on every tick
   task automatic random_ticks(input int count, input bit with_hold_off);
      twrsm_pkg::req_payload_type item;
      for (int i = 0; i < count; i++) begin
         item.start_req  = ($urandom_range(0, 99) < 25);
         item.op         = $urandom_range(0, 1) ? twrsm_pkg::OP_READ : twrsm_pkg::OP_WRITE;
         item.address    = 8'($urandom);
         item.write_data = 8'($urandom);
         item.io_in      = 1'($urandom_range(0, 1));
         send_tick(item);
         if (with_hold_off && i == count / 2) hold_off_req = 1'b1;
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_payload     = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      sent_count      = 0;
      burst_left      = 0;
      quiet           = 1'b0;
      hold_off_req    = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all delays zero after reset: extreme bytes, both kinds
      do_transfer(twrsm_pkg::OP_WRITE, 8'h00, 8'hFF, 1'b0, IO_LOW);
      do_transfer(twrsm_pkg::OP_READ, 8'hFF, 8'h00, 1'b0, IO_HIGH);
      // start held high while busy must be ignored
      do_transfer(twrsm_pkg::OP_WRITE, 8'hA5, 8'h5A, 1'b1, IO_RANDOM);
      do_transfer(twrsm_pkg::OP_READ, 8'h5A, 8'hA5, 1'b0, IO_RANDOM);

      // short waits everywhere
      write_delays(16'd3, 16'd5, 16'd2, 16'd1, 16'd2);
      do_transfer(twrsm_pkg::OP_WRITE, 8'h3C, 8'hC3, 1'b0, IO_RANDOM);
      do_transfer(twrsm_pkg::OP_READ, 8'hC3, 8'h3C, 1'b1, IO_RANDOM);

      // enable setup shorter than data setup: setup wait saturates at zero
      write_delays(16'd0, 16'd1, 16'd4, 16'd0, 16'd0);
      do_transfer(twrsm_pkg::OP_WRITE, 8'h81, 8'h7E, 1'b0, IO_RANDOM);

      // long waits, run without idling to keep it short
      @(posedge clock);
      quiet = 1'b1;
      write_delays(16'd20, 16'd50, 16'd0, 16'd0, 16'd30);
      do_transfer(twrsm_pkg::OP_WRITE, 8'h96, 8'h69, 1'b0, IO_RANDOM);
      do_transfer(twrsm_pkg::OP_READ, 8'h69, 8'h96, 1'b0, IO_RANDOM);

      // wide per-bit timing
      write_delays(16'd1, 16'd20, 16'd5, 16'd3, 16'd1);
      do_transfer(twrsm_pkg::OP_WRITE, 8'h5C, 8'hE1, 1'b0, IO_RANDOM);
      do_transfer(twrsm_pkg::OP_READ, 8'hE1, 8'h5C, 1'b0, IO_RANDOM);
      @(posedge clock);
      quiet = 1'b0;

      // random phases with small random timing, long hold-off in one of them
      for (int phase_num = 0; phase_num < RANDOM_PHASES; phase_num++) begin
         write_delays(short_delay(), short_delay(), short_delay(), short_delay(),
                      short_delay());
         random_ticks(PHASE_TICKS, phase_num == 3);
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("three_wire_rtc_serial_master_core test passed");
      else
         $display("three_wire_rtc_serial_master_core test failed");
      $finish;
   end

endmodule

### three_wire_rtc_serial_master_core.f
+incdir+rtl
rtl/twrsm_pkg.sv
rtl/twrsm_engine.sv
rtl/twrsm_skid.sv
rtl/three_wire_rtc_serial_master_core.sv
tb/sv/pin_tick_monitor.sv
tb/sv/tb_top.sv
